### design/ehps_pkg.sv
// Shared widths, constants and the result type of the half-period statistics block.
`default_nettype none

package ehps_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned PinW = 3;
  localparam int unsigned FieldW = 19;
  localparam logic [FieldW-1:0] FieldMax = {FieldW{1'b1}};
  localparam int unsigned DefMaxSamples = 524288;

  // Five result fields packed back to back, padded to whole bytes.
  localparam int unsigned ResultW = 5 * FieldW;
  localparam int unsigned OutTdataW = ((ResultW + 7) / 8) * 8;

  typedef struct packed {
    logic [FieldW-1:0] half_period_count;
    logic [FieldW-1:0] half_period_sum;
    logic [FieldW-1:0] max_half_period;
    logic [FieldW-1:0] min_half_period;
    logic [FieldW-1:0] transition_count;
  } result_t;

endpackage

`default_nettype wire

### design/ehps_core.sv
// Capture state and per-sample update of the half-period statistics.
`default_nettype none

module ehps_core #(
  parameter int unsigned MAX_SAMPLES = ehps_pkg::DefMaxSamples
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire logic              level_i,
  input  wire logic              last_i,
  output ehps_pkg::result_t      result_o
);

  localparam int unsigned FW = ehps_pkg::FieldW;
  localparam int unsigned IdxW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned GW = ((IdxW + 1) > FW) ? (IdxW + 1) : FW;
  localparam logic [IdxW:0] MaxCnt = (IdxW + 1)'(MAX_SAMPLES);
  localparam logic [FW-1:0] FMax = ehps_pkg::FieldMax;

  logic            first_q, first_d;
  logic            prev_q, prev_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] last_edge_q, last_edge_d;
  logic [FW-1:0]   edges_q, edges_d;
  logic [FW-1:0]   shortest_q, shortest_d;
  logic [FW-1:0]   longest_q, longest_d;
  logic [FW-1:0]   sum_q, sum_d;
  logic [FW-1:0]   gaps_q, gaps_d;

  logic [IdxW:0]   next_idx;
  logic [IdxW:0]   diff;
  logic [GW-1:0]   gap_ext;
  logic [FW-1:0]   gap;
  logic [FW:0]     sum_ext;

  assign next_idx = {1'b0, idx_q} + {{IdxW{1'b0}}, 1'b1};
  assign diff     = next_idx - {1'b0, last_edge_q};
  assign gap_ext  = GW'(diff);
  assign gap      = (gap_ext > GW'(FMax)) ? FMax : gap_ext[FW-1:0];
  assign sum_ext  = {1'b0, sum_q} + {1'b0, gap};

  always_comb begin
    first_d     = first_q;
    prev_d      = prev_q;
    idx_d       = idx_q;
    last_edge_d = last_edge_q;
    edges_d     = edges_q;
    shortest_d  = shortest_q;
    longest_d   = longest_q;
    sum_d       = sum_q;
    gaps_d      = gaps_q;

    if (valid_i) begin
      if (first_q) begin
        first_d = 1'b0;
        prev_d  = level_i;
        idx_d   = '0;
      end else if (next_idx < MaxCnt) begin
        idx_d = next_idx[IdxW-1:0];
        if (level_i != prev_q) begin
          // The first change only marks where the next half-period starts.
          if (edges_q != '0) begin
            if (gap < shortest_q) shortest_d = gap;
            if (gap > longest_q) longest_d = gap;
            sum_d  = sum_ext[FW] ? FMax : sum_ext[FW-1:0];
            gaps_d = (gaps_q == FMax) ? gaps_q : gaps_q + 1'b1;
          end
          edges_d     = (edges_q == FMax) ? edges_q : edges_q + 1'b1;
          last_edge_d = next_idx[IdxW-1:0];
          prev_d      = level_i;
        end
      end
    end

    result_o.transition_count  = edges_d;
    result_o.min_half_period   = (gaps_d != '0) ? shortest_d : '0;
    result_o.max_half_period   = longest_d;
    result_o.half_period_sum   = sum_d;
    result_o.half_period_count = gaps_d;

    if (valid_i && last_i) begin
      first_d     = 1'b1;
      prev_d      = 1'b0;
      idx_d       = '0;
      last_edge_d = '0;
      edges_d     = '0;
      shortest_d  = FMax;
      longest_d   = '0;
      sum_d       = '0;
      gaps_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      prev_q      <= 1'b0;
      idx_q       <= '0;
      last_edge_q <= '0;
      edges_q     <= '0;
      shortest_q  <= FMax;
      longest_q   <= '0;
      sum_q       <= '0;
      gaps_q      <= '0;
    end else begin
      first_q     <= first_d;
      prev_q      <= prev_d;
      idx_q       <= idx_d;
      last_edge_q <= last_edge_d;
      edges_q     <= edges_d;
      shortest_q  <= shortest_d;
      longest_q   <= longest_d;
      sum_q       <= sum_d;
      gaps_q      <= gaps_d;
    end
  end

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && last_i |=> first_q && edges_q == '0 && gaps_q == '0)
    else $error("capture state not cleared after last beat");

  a_gaps_le_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gaps_q <= edges_q)
    else $error("more half-periods than transitions");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gaps_q != '0 |-> shortest_q <= longest_q && shortest_q != '0)
    else $error("minimum half-period inconsistent with maximum");

endmodule

`default_nettype wire

### design/edge_half_period_statistics.sv
// Top level: input stage, statistics core and result register of the half-period block.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[7:0] sample, tlast last_sample
//  m_axis    out        tdata[94:0] five 19-bit statistics, zero padded to 96
//  cfg       in         cfg_wdata_i[2:0] pin_select, written when cfg_we_i is high
//
// One sample beat is accepted per cycle unless a stalled result holds the input stage;
// a result beat is offered once the last sample has passed the input register, then
// the result register.
// Reset clears the capture state and selects pin 0.
// A stalled result only stops input when the input stage holds a last sample.
`default_nettype none

module edge_half_period_statistics #(
  parameter int unsigned MAX_SAMPLES = ehps_pkg::DefMaxSamples
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [ehps_pkg::PinW-1:0]          cfg_wdata_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [ehps_pkg::SampleW-1:0]       s_axis_tdata,  // [7:0] sample
  input  wire logic                               s_axis_tlast,  // last_sample
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [18:0] transition_count, [37:19] min_half_period, [56:38] max_half_period,
  // [75:57] half_period_sum, [94:76] half_period_count, [95] zero
  output logic [ehps_pkg::OutTdataW-1:0]          m_axis_tdata
);

  logic [ehps_pkg::PinW-1:0]    pin_q;
  logic                         in_valid_q;
  logic [ehps_pkg::SampleW-1:0] in_sample_q;
  logic                         in_last_q;
  logic                         out_valid_q;
  ehps_pkg::result_t            out_data_q;
  ehps_pkg::result_t            core_result;
  logic                         advance;
  logic                         in_fire;
  logic                         out_fire;

  assign out_fire = m_axis_tvalid && m_axis_tready;
  // The stage moves on unless it carries a result that has nowhere to go.
  assign advance  = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q <= '0;
    end else if (cfg_we_i) begin
      pin_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_sample_q <= s_axis_tdata;
      in_last_q   <= s_axis_tlast;
    end
  end

  ehps_core #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (advance),
    .level_i (in_sample_q[pin_q]),
    .last_i  (in_last_q),
    .result_o(core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_data_q <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ehps_pkg::OutTdataW - ehps_pkg::ResultW){1'b0}},
                          out_data_q.half_period_count,
                          out_data_q.half_period_sum,
                          out_data_q.max_half_period,
                          out_data_q.min_half_period,
                          out_data_q.transition_count};

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(advance && in_last_q))
    else $error("result beat without a last sample behind it");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !(advance && in_last_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
